@@ rtl/core/tri_ras_pkg.sv @@
// Package with the shared types and constants of the triangle rasterizer.
`timescale 1ns / 1ps
package tri_ras_pkg;

  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic signed [23:0] DEPTH_FAR = 24'sh7FFFFF;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLR_STEP,
    CMD_READ_ISSUE,
    CMD_READ_TAKE,
    CMD_PIX_START,
    CMD_SAMP_EVAL,
    CMD_SAMP_DIV,
    CMD_SAMP_RD,
    CMD_SAMP_WR,
    CMD_SAMP_NEXT,
    CMD_AVG_RD,
    CMD_AVG_ACC,
    CMD_FRAME_WR,
    CMD_PIX_NEXT,
    CMD_DONE_IDLE
  } ras_cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CLR,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_RD_TAKE,
    ST_PIX,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_SRD,
    ST_SRD_WAIT,
    ST_SWR,
    ST_AVG_RD,
    ST_AVG_WAIT,
    ST_AVG_ACC,
    ST_FWR,
    ST_NEXT,
    ST_OUT
  } ras_state_e;

  typedef struct packed {
    logic       in_box;    // current pixel still inside the clipped box
    logic       covered;   // current sample strictly inside
    logic       div_done;
    logic       nearer;    // computed depth nearer than stored one
    logic       last_samp; // sample counter at its last value
    logic       hit;       // pixel has at least one covered sample
    logic       clr_done;
  } ras_status_t;

endpackage

@@ rtl/core/tri_ras_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tri_ras_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/core/tri_ras_ctrl.sv @@
// Controller state machine of the triangle rasterizer.
`timescale 1ns / 1ps
module tri_ras_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              func_i,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  tri_ras_pkg::ras_status_t status_i,
  output tri_ras_pkg::ras_cmd_e   cmd_o
);
  import tri_ras_pkg::*;

  ras_state_e state_q, state_d;
  logic       boot_q, boot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      boot_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      boot_q  <= boot_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    boot_d    = boot_q;
    cmd_o     = CMD_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        case (func_i)
          FUNC_DRAW:  state_d = ST_PIX;
          FUNC_CLEAR: state_d = ST_CLR;
          FUNC_READ:  state_d = ST_RD_ISSUE;
          default:    state_d = ST_OUT;
        endcase
      end
      ST_CLR: begin
        cmd_o = CMD_CLR_STEP;
        if (status_i.clr_done) begin
          // The pass after reset produces no result.
          boot_d  = 1'b0;
          state_d = boot_q ? ST_IDLE : ST_OUT;
        end
      end
      ST_RD_ISSUE: begin
        cmd_o   = CMD_READ_ISSUE;
        state_d = ST_RD_TAKE;
      end
      ST_RD_WAIT: state_d = ST_RD_TAKE;
      ST_RD_TAKE: begin
        cmd_o   = CMD_READ_TAKE;
        state_d = ST_OUT;
      end
      ST_PIX: begin
        if (status_i.in_box) begin
          cmd_o   = CMD_PIX_START;
          state_d = ST_EVAL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_EVAL: begin
        cmd_o   = CMD_SAMP_EVAL;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (status_i.covered) begin
          cmd_o   = CMD_SAMP_DIV;
          state_d = ST_DIV;
        end else begin
          cmd_o = CMD_SAMP_NEXT;
          if (status_i.last_samp) begin
            state_d = status_i.hit ? ST_AVG_RD : ST_NEXT;
          end else begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_SRD;
        end
      end
      ST_SRD: begin
        cmd_o   = CMD_SAMP_RD;
        state_d = ST_SRD_WAIT;
      end
      ST_SRD_WAIT: state_d = ST_SWR;
      ST_SWR: begin
        cmd_o = CMD_SAMP_WR;
        if (status_i.last_samp) begin
          state_d = ST_AVG_RD;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_AVG_RD: begin
        cmd_o   = CMD_AVG_RD;
        state_d = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: state_d = ST_AVG_ACC;
      ST_AVG_ACC: begin
        cmd_o = CMD_AVG_ACC;
        if (status_i.last_samp) begin
          state_d = ST_FWR;
        end else begin
          state_d = ST_AVG_RD;
        end
      end
      ST_FWR: begin
        cmd_o   = CMD_FRAME_WR;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o   = CMD_PIX_NEXT;
        state_d = ST_PIX;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd_o   = CMD_DONE_IDLE;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

@@ rtl/core/tri_ras_dp.sv @@
// Datapath of the triangle rasterizer: edge functions, depth divider, stores.
`timescale 1ns / 1ps
module tri_ras_dp #(
  parameter int ScreenWidth  = 256,
  parameter int ScreenHeight = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tri_ras_pkg::ras_cmd_e   cmd_i,
  input  logic [1:0]              func_i,
  input  logic signed [15:0]      vert0_x_i,
  input  logic signed [15:0]      vert0_y_i,
  input  logic signed [23:0]      vert0_depth_i,
  input  logic signed [15:0]      vert1_x_i,
  input  logic signed [15:0]      vert1_y_i,
  input  logic signed [23:0]      vert1_depth_i,
  input  logic signed [15:0]      vert2_x_i,
  input  logic signed [15:0]      vert2_y_i,
  input  logic signed [23:0]      vert2_depth_i,
  input  logic [23:0]             tri_rgb_i,
  input  logic [15:0]             pixel_addr_i,
  output tri_ras_pkg::ras_status_t status_o,
  output logic [1:0]              func_o,
  output logic [23:0]             pixel_rgb_o,
  output logic [16:0]             pixels_written_o
);
  import tri_ras_pkg::*;

  localparam int FrameCount  = ScreenWidth * ScreenHeight;
  localparam int SampleCount = 4 * FrameCount;
  localparam int FAw = $clog2(FrameCount) > 0 ? $clog2(FrameCount) : 1;
  localparam int SAw = $clog2(SampleCount);
  localparam int XW  = $clog2(ScreenWidth) + 1;
  localparam int YW  = $clog2(ScreenHeight) + 1;
  localparam int SxW = XW + 1;
  localparam int CntW = $clog2(FrameCount + 1);
  // Edge values reach about 2^34, products with depth about 2^58.
  localparam int EW = 36;
  localparam int NW = 64;
  localparam int DivSteps = NW;
  localparam int DcW = $clog2(DivSteps + 1);

  logic [1:0]  func_q;
  logic signed [15:0] vx_q [3];
  logic signed [15:0] vy_q [3];
  logic signed [23:0] vd_q [3];
  logic [23:0] rgb_q;
  logic [15:0] addr_q;
  logic signed [16:0] hi_x_q, hi_y_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q, y0_q;
  logic [1:0]  samp_q; // bit 1 selects i, bit 0 selects j
  logic        hit_q;
  logic [CntW-1:0] cnt_q;
  logic [23:0] rgb_out_q;
  logic signed [EW-1:0] e01_q, e12_q, e20_q;
  logic signed [NW-1:0] num_q;
  logic [EW-1:0] area_q;
  logic        neg_q, cov_q;
  logic [NW-1:0] quo_q, rem_q;
  logic [NW-1:0] nabs_q;
  logic [DcW-1:0] dcnt_q;
  logic        dbusy_q;
  logic signed [23:0] z_q;
  logic [9:0]  r_acc_q, g_acc_q, b_acc_q;
  logic [SAw:0] clr_q;

  // Bounding box limits from the input vertices.
  logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
  always_comb begin
    lo_x = vert0_x_i; hi_x = vert0_x_i;
    lo_y = vert0_y_i; hi_y = vert0_y_i;
    if (vert1_x_i < lo_x) lo_x = vert1_x_i;
    if (vert2_x_i < lo_x) lo_x = vert2_x_i;
    if (vert1_x_i > hi_x) hi_x = vert1_x_i;
    if (vert2_x_i > hi_x) hi_x = vert2_x_i;
    if (vert1_y_i < lo_y) lo_y = vert1_y_i;
    if (vert2_y_i < lo_y) lo_y = vert2_y_i;
    if (vert1_y_i > hi_y) hi_y = vert1_y_i;
    if (vert2_y_i > hi_y) hi_y = vert2_y_i;
  end

  logic [XW-1:0] x_start;
  logic [YW-1:0] y_start;
  logic [11:0] lox_px, loy_px;
  always_comb begin
    lox_px = lo_x[15:4];
    loy_px = lo_y[15:4];
    if (lo_x < 0) begin
      x_start = '0;
    end else if ({1'b0, lox_px} >= 13'(ScreenWidth)) begin
      x_start = XW'(ScreenWidth);
    end else begin
      x_start = XW'(lox_px);
    end
    if (lo_y < 0) begin
      y_start = '0;
    end else if ({1'b0, loy_px} >= 13'(ScreenHeight)) begin
      y_start = YW'(ScreenHeight);
    end else begin
      y_start = YW'(loy_px);
    end
  end

  logic x_ok, y_ok;
  assign x_ok = (x_q < XW'(ScreenWidth)) &&
                ($signed({2'b00, x_q, 4'b0000}) < 22'(hi_x_q));
  assign y_ok = (y_q < YW'(ScreenHeight)) &&
                ($signed({2'b00, y_q, 4'b0000}) < 22'(hi_y_q));

  // Sample point in 1/16 pixel units.
  logic signed [EW-1:0] px, py;
  assign px = EW'({x_q, 4'b0000}) + (samp_q[1] ? EW'(8) : EW'(0));
  assign py = EW'({y_q, 4'b0000}) + (samp_q[0] ? EW'(8) : EW'(0));

  logic signed [EW-1:0] ax [3], ay [3], bx [3], by [3], ev [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax[k] = EW'(vx_q[k]);
      ay[k] = EW'(vy_q[k]);
      bx[k] = EW'(vx_q[(k + 1) % 3]);
      by[k] = EW'(vy_q[(k + 1) % 3]);
      ev[k] = (bx[k] - ax[k]) * (py - ay[k]) - (by[k] - ay[k]) * (px - ax[k]);
    end
  end

  logic [SAw-1:0] samp_idx;
  logic [SxW-1:0] sx;
  logic [YW:0]    sy;
  assign sx = {x_q, samp_q[1]};
  assign sy = {y_q, samp_q[0]};
  assign samp_idx = SAw'(sy * (2 * ScreenWidth) + sx);

  logic [FAw-1:0] frame_idx;
  assign frame_idx = FAw'((ScreenHeight - 1 - y_q) * ScreenWidth + x_q);

  // Stores.
  logic        sd_we, sc_we, fc_we;
  logic [SAw-1:0] s_addr;
  logic [FAw-1:0] f_addr;
  logic [23:0] sd_wd, sc_wd, fc_wd, sd_rd, sc_rd, fc_rd;
  logic clearing;
  assign clearing = (cmd_i == CMD_CLR_STEP) && !clr_q[SAw];

  always_comb begin
    sd_we  = 1'b0;
    sc_we  = 1'b0;
    fc_we  = 1'b0;
    s_addr = samp_idx;
    f_addr = frame_idx;
    sd_wd  = z_q;
    sc_wd  = rgb_q;
    fc_wd  = {r_acc_q[9:2], g_acc_q[9:2], b_acc_q[9:2]};
    if (clearing) begin
      s_addr = clr_q[SAw-1:0];
      f_addr = clr_q[FAw-1:0];
      sd_we  = 1'b1;
      sc_we  = 1'b1;
      fc_we  = clr_q < (SAw+1)'(FrameCount);
      sd_wd  = DEPTH_FAR;
      sc_wd  = '0;
      fc_wd  = '0;
    end else if (cmd_i == CMD_READ_ISSUE) begin
      f_addr = addr_q[FAw-1:0];
    end else if (cmd_i == CMD_SAMP_WR) begin
      sd_we = status_o.nearer;
      sc_we = status_o.nearer;
    end else if (cmd_i == CMD_FRAME_WR) begin
      fc_we = 1'b1;
    end
  end

  tri_ras_ram #(.Width(24), .Depth(SampleCount)) u_sdepth (
    .clk_i, .we_i(sd_we), .addr_i(s_addr), .wdata_i(sd_wd), .rdata_o(sd_rd));
  tri_ras_ram #(.Width(24), .Depth(SampleCount)) u_scolor (
    .clk_i, .we_i(sc_we), .addr_i(s_addr), .wdata_i(sc_wd), .rdata_o(sc_rd));
  tri_ras_ram #(.Width(24), .Depth(1 << FAw)) u_fcolor (
    .clk_i, .we_i(fc_we), .addr_i(f_addr), .wdata_i(fc_wd), .rdata_o(fc_rd));

  // Restoring divider step on magnitudes.
  logic [NW:0]   rem_sh;
  logic [NW:0]   rem_sub;
  assign rem_sh  = {rem_q, nabs_q[NW-1]};
  assign rem_sub = rem_sh - (NW+1)'(area_q);

  // Floor of the signed quotient from the magnitude quotient.
  logic signed [NW-1:0] zq;
  always_comb begin
    if (neg_q) begin
      zq = -$signed(quo_q) - ((rem_q != '0) ? NW'(1) : NW'(0));
    end else begin
      zq = $signed(quo_q);
    end
  end

  logic signed [NW-1:0] n_sum, a_sum;
  always_comb begin
    a_sum = NW'(e01_q) + NW'(e12_q) + NW'(e20_q);
    n_sum = NW'(e12_q) * NW'(vd_q[0]) + NW'(e20_q) * NW'(vd_q[1]) +
            NW'(e01_q) * NW'(vd_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      dbusy_q <= 1'b0;
      func_q  <= FUNC_CLEAR;
      cnt_q   <= '0;
      rgb_out_q <= '0;
    end else begin
      unique case (cmd_i)
        CMD_LOAD: begin
          func_q <= func_i;
          vx_q[0] <= vert0_x_i; vx_q[1] <= vert1_x_i; vx_q[2] <= vert2_x_i;
          vy_q[0] <= vert0_y_i; vy_q[1] <= vert1_y_i; vy_q[2] <= vert2_y_i;
          vd_q[0] <= vert0_depth_i; vd_q[1] <= vert1_depth_i;
          vd_q[2] <= vert2_depth_i;
          rgb_q  <= tri_rgb_i;
          addr_q <= pixel_addr_i;
          hi_x_q <= 17'(hi_x);
          hi_y_q <= 17'(hi_y);
          x_q    <= x_start;
          y_q    <= y_start;
          y0_q   <= y_start;
          cnt_q  <= '0;
          rgb_out_q <= '0;
          clr_q  <= '0;
        end
        CMD_CLR_STEP: begin
          if (!clr_q[SAw]) clr_q <= clr_q + 1'b1;
        end
        CMD_READ_TAKE: begin
          rgb_out_q <= ({16'h0, addr_q} < 32'(FrameCount)) ? fc_rd : '0;
        end
        CMD_PIX_START: begin
          samp_q <= '0;
          hit_q  <= 1'b0;
          r_acc_q <= '0; g_acc_q <= '0; b_acc_q <= '0;
        end
        CMD_SAMP_EVAL: begin
          e01_q <= ev[0];
          e12_q <= ev[1];
          e20_q <= ev[2];
          cov_q <= (ev[0] > 0 && ev[1] > 0 && ev[2] > 0) ||
                   (ev[0] < 0 && ev[1] < 0 && ev[2] < 0);
        end
        CMD_SAMP_DIV: begin
          hit_q   <= 1'b1;
          neg_q   <= (a_sum < 0) ? (n_sum > 0) : (n_sum < 0);
          area_q  <= (a_sum < 0) ? EW'(-a_sum) : EW'(a_sum);
          nabs_q  <= (n_sum < 0) ? NW'(-n_sum) : NW'(n_sum);
          quo_q   <= '0;
          rem_q   <= '0;
          dcnt_q  <= '0;
          dbusy_q <= 1'b1;
        end
        CMD_SAMP_WR: begin
          samp_q <= samp_q + 2'd1;
        end
        CMD_SAMP_NEXT: begin
          samp_q <= samp_q + 2'd1;
        end
        CMD_AVG_ACC: begin
          r_acc_q <= r_acc_q + 10'(sc_rd[23:16]);
          g_acc_q <= g_acc_q + 10'(sc_rd[15:8]);
          b_acc_q <= b_acc_q + 10'(sc_rd[7:0]);
          samp_q  <= samp_q + 2'd1;
        end
        CMD_FRAME_WR: begin
          cnt_q <= cnt_q + 1'b1;
        end
        CMD_PIX_NEXT: begin
          samp_q <= '0;
          if (y_ok && (YW'(y_q + 1'b1) < YW'(ScreenHeight)) &&
              ($signed({2'b00, YW'(y_q + 1'b1), 4'b0000}) < 22'(hi_y_q))) begin
            y_q <= y_q + 1'b1;
          end else begin
            y_q <= y0_q;
            x_q <= x_q + 1'b1;
          end
        end
        default: ;
      endcase
      if (dbusy_q) begin
        if (!rem_sub[NW]) begin
          rem_q <= rem_sub[NW-1:0];
          quo_q <= {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[NW-1:0];
          quo_q <= {quo_q[NW-2:0], 1'b0};
        end
        nabs_q <= {nabs_q[NW-2:0], 1'b0};
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == DcW'(DivSteps - 1)) dbusy_q <= 1'b0;
      end
      if (cmd_i == CMD_SAMP_RD) begin
        z_q <= zq[23:0];
      end
      if (cmd_i == CMD_SAMP_WR && !status_o.nearer) begin
        // Depth not nearer: sample left as it was.
      end
    end
  end

  logic div_fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_fin_q <= 1'b0;
    end else begin
      div_fin_q <= dbusy_q && (dcnt_q == DcW'(DivSteps - 1));
    end
  end

  assign status_o.in_box    = x_ok && y_ok;
  assign status_o.covered   = cov_q;
  assign status_o.div_done  = div_fin_q;
  assign status_o.nearer    = $signed(z_q) < $signed(sd_rd);
  assign status_o.last_samp = samp_q == 2'd3;
  assign status_o.hit       = hit_q;
  assign status_o.clr_done  = clr_q[SAw];

  assign func_o           = func_q;
  assign pixel_rgb_o      = rgb_out_q;
  assign pixels_written_o = 17'(cnt_q);
endmodule

@@ rtl/core/triangle_rasterizer_ssaa_zbuffer_unit.sv @@
// A triangle rasterizer with 2x2 supersampling and a per-sample depth buffer: a draw
// transfer walks the clipped bounding box one pixel at a time; a covered sample is bound
// by the bit-serial depth divider (one quotient bit per cycle). A clear walks all
// 4*SCREEN_WIDTH*SCREEN_HEIGHT sample entries at one per cycle, and this same pass runs
// after reset before the first transfer is accepted.
`timescale 1ns / 1ps
module triangle_rasterizer_ssaa_zbuffer_unit #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] vert0_x_i,
  input  logic signed [15:0] vert0_y_i,
  input  logic signed [23:0] vert0_depth_i,
  input  logic signed [15:0] vert1_x_i,
  input  logic signed [15:0] vert1_y_i,
  input  logic signed [23:0] vert1_depth_i,
  input  logic signed [15:0] vert2_x_i,
  input  logic signed [15:0] vert2_y_i,
  input  logic signed [23:0] vert2_depth_i,
  input  logic [23:0]        tri_rgb_i,
  input  logic [15:0]        pixel_addr_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        pixel_rgb_o,
  output logic [16:0]        pixels_written_o
);
  import tri_ras_pkg::*;

  ras_status_t status;
  ras_cmd_e    cmd;
  logic [1:0]  func_q;

  tri_ras_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .func_i(func_q),
    .out_valid, .out_ready, .status_i(status), .cmd_o(cmd));

  tri_ras_dp #(.ScreenWidth(SCREEN_WIDTH), .ScreenHeight(SCREEN_HEIGHT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .func_i,
    .vert0_x_i, .vert0_y_i, .vert0_depth_i,
    .vert1_x_i, .vert1_y_i, .vert1_depth_i,
    .vert2_x_i, .vert2_y_i, .vert2_depth_i,
    .tri_rgb_i, .pixel_addr_i, .status_o(status), .func_o(func_q),
    .pixel_rgb_o, .pixels_written_o);

  // Results of draws carry no colour, reads no count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && func_q != FUNC_DRAW |-> pixels_written_o == '0)
    else $error("count on non-draw result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && func_q != FUNC_READ |-> pixel_rgb_o == '0)
    else $error("colour on non-read result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("accepting while result pending");
endmodule
